// ===== design/mvm_pkg.sv =====
// Shared constants, types and a helper function for the matrix-vector multiplier.
`timescale 1ns / 1ps

package mvm_pkg;

   // Datapath geometry.
   localparam int LANES        = 4;
   localparam int ELEMENT_BITS = 16;
   localparam int MAX_LENGTH   = 512;
   localparam int GROUPS       = MAX_LENGTH / LANES;
   localparam int GROUP_BITS   = $clog2(GROUPS);
   localparam int ROW_BITS     = $clog2(MAX_LENGTH);
   localparam int COUNT_BITS   = ROW_BITS + 1;
   localparam int CFG_BITS     = 8;
   localparam int WORD_BITS    = LANES * ELEMENT_BITS;
   localparam int PROD_BITS    = 2 * ELEMENT_BITS;
   localparam int TREE_BITS    = PROD_BITS + $clog2(LANES);
   localparam int ACC_BITS     = 41;

   // Group count register holds up to GROUPS itself.
   typedef logic [GROUP_BITS:0] groups_type;

   // Kind of an input beat.
   typedef enum logic {
      REQ_VECTOR = 1'b0,
      REQ_MATRIX = 1'b1
   } req_kind_type;

   // Control that travels with a matrix beat down the pipeline.
   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctl_type;

   // Clamp the group count register: zero acts as one, large values as GROUPS.
   function automatic groups_type eff_groups(input logic [CFG_BITS-1:0] raw);
      groups_type result;
      if (raw == '0) begin
         result = groups_type'(1);
      end else if (raw > CFG_BITS'(GROUPS)) begin
         result = groups_type'(GROUPS);
      end else begin
         result = raw[GROUP_BITS:0];
      end
      return result;
   endfunction

endpackage

// ===== design/mvm_ifs.sv =====
// Valid/ready channel interfaces for request and response beats.
`timescale 1ns / 1ps

interface mvm_req_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      req_type;
   logic        [mvm_pkg::GROUP_BITS-1:0]     col_group;
   logic signed [mvm_pkg::ELEMENT_BITS-1:0]   lane0;
   logic signed [mvm_pkg::ELEMENT_BITS-1:0]   lane1;
   logic signed [mvm_pkg::ELEMENT_BITS-1:0]   lane2;
   logic signed [mvm_pkg::ELEMENT_BITS-1:0]   lane3;

   modport source (output valid, req_type, col_group, lane0, lane1, lane2, lane3,
                   input ready);
   modport sink   (input valid, req_type, col_group, lane0, lane1, lane2, lane3,
                   output ready);
endinterface

interface mvm_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic        [mvm_pkg::ROW_BITS-1:0]   row_index;
   logic signed [mvm_pkg::ACC_BITS-1:0]   row_sum;

   modport source (output valid, row_index, row_sum, input ready);
   modport sink   (input valid, row_index, row_sum, output ready);
endinterface

// ===== design/mvm_lane.sv =====
// One multiplier lane: a registered signed product of a matrix and a vector element.
`timescale 1ns / 1ps

module mvm_lane (
   input  logic                                    clock,
   input  logic                                    load,
   input  logic signed [mvm_pkg::ELEMENT_BITS-1:0] mat_elem,
   input  logic signed [mvm_pkg::ELEMENT_BITS-1:0] vec_elem,
   output logic signed [mvm_pkg::PROD_BITS-1:0]    prod_ff
);

   // The product is exact in twice the element width.
   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= mat_elem * vec_elem;
      end
   end

endmodule

// ===== design/mvm_merge.sv =====
// Adder tree over the lane products, row accumulator, row counter and output register.
`timescale 1ns / 1ps

module mvm_merge (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mvm_pkg::stage_ctl_type                in_ctl,
   input  logic signed [mvm_pkg::PROD_BITS-1:0]  prod [mvm_pkg::LANES],
   input  mvm_pkg::groups_type                   groups,
   output logic                                  in_ready,
   mvm_rsp_if.source                             rsp
);

   logic signed [mvm_pkg::TREE_BITS-1:0] tree_sum;
   logic signed [mvm_pkg::TREE_BITS-1:0] tree_ff;
   mvm_pkg::stage_ctl_type               tree_ctl_ff;
   mvm_pkg::stage_ctl_type               tree_ctl_in;
   logic signed [mvm_pkg::ACC_BITS-1:0]  acc_ff;
   logic signed [mvm_pkg::ACC_BITS-1:0]  acc_in;
   logic signed [mvm_pkg::ACC_BITS-1:0]  acc_sum;
   logic        [mvm_pkg::ROW_BITS-1:0]  row_ff;
   logic        [mvm_pkg::ROW_BITS-1:0]  row_in;
   logic        [mvm_pkg::COUNT_BITS-1:0] row_next;
   logic        [mvm_pkg::COUNT_BITS-1:0] row_limit;
   logic                                 out_valid_ff;
   logic                                 out_valid_in;
   logic        [mvm_pkg::ROW_BITS-1:0]  out_row_ff;
   logic signed [mvm_pkg::ACC_BITS-1:0]  out_sum_ff;
   logic                                 out_free;
   logic                                 acc_go;
   logic                                 emit;
   logic                                 tree_take;

   // Sum the lane products; the tree grows by the log of the lane count.
   always_comb begin
      tree_sum = '0;
      for (int k = 0; k < mvm_pkg::LANES; k++) begin
         tree_sum = tree_sum + mvm_pkg::TREE_BITS'(prod[k]);
      end
   end

   // Only a beat that closes a row needs the output register.
   assign out_free  = !out_valid_ff || rsp.ready;
   assign acc_go    = tree_ctl_ff.valid && (!tree_ctl_ff.last || out_free);
   assign emit      = acc_go && tree_ctl_ff.last;
   assign tree_take = !tree_ctl_ff.valid || acc_go;
   assign in_ready  = tree_take;

   // Accumulate, and at the end of a row report and advance the row counter.
   always_comb begin
      acc_sum   = acc_ff + mvm_pkg::ACC_BITS'(tree_ff);
      row_next  = mvm_pkg::COUNT_BITS'(row_ff) + mvm_pkg::COUNT_BITS'(1);
      row_limit = mvm_pkg::COUNT_BITS'(int'(groups) * mvm_pkg::LANES);
      acc_in    = acc_ff;
      row_in    = row_ff;
      if (acc_go) begin
         if (tree_ctl_ff.last) begin
            acc_in = '0;
            if (row_next >= row_limit) begin
               row_in = '0;
            end else begin
               row_in = row_next[mvm_pkg::ROW_BITS-1:0];
            end
         end else begin
            acc_in = acc_sum;
         end
      end
      tree_ctl_in = tree_take ? in_ctl : tree_ctl_ff;
      if (out_free) begin
         out_valid_in = emit;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         tree_ctl_ff  <= '0;
         acc_ff       <= '0;
         row_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         tree_ctl_ff  <= tree_ctl_in;
         acc_ff       <= acc_in;
         row_ff       <= row_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (tree_take) begin
         tree_ff <= tree_sum;
      end
      if (emit) begin
         out_row_ff <= row_ff;
         out_sum_ff <= acc_sum;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.row_index = out_row_ff;
   assign rsp.row_sum   = out_sum_ff;

endmodule

// ===== design/matrix_vector_multiply_top.sv =====
// Top level of the matrix-vector multiplier: vector store, lane array and merge stage.
// Throughput: one beat per cycle unless the response side stalls; the vector store takes
// a write or a read each cycle, and the four lanes each retire one 16 x 16 product per
// cycle while beats keep flowing.
// Reset clears the pipeline, accumulator, row counter and sets the group count to 128;
// the vector store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module matrix_vector_multiply_top (
   input  logic                             clock,
   input  logic                             reset,
   mvm_req_if.sink                          req_bus,
   mvm_rsp_if.source                        rsp_bus,
   input  logic                             csr_we,
   input  logic [mvm_pkg::CFG_BITS-1:0]     csr_wdata
);

   logic [mvm_pkg::CFG_BITS-1:0]            groups_in_use_ff;
   logic [mvm_pkg::CFG_BITS-1:0]            groups_in_use_in;
   mvm_pkg::groups_type                     groups;
   logic [mvm_pkg::WORD_BITS-1:0]           vector_store [mvm_pkg::GROUPS];
   logic [mvm_pkg::WORD_BITS-1:0]           vec_rd_ff;
   logic [mvm_pkg::WORD_BITS-1:0]           vec_word;
   logic signed [mvm_pkg::ELEMENT_BITS-1:0] mat_in [mvm_pkg::LANES];
   logic signed [mvm_pkg::ELEMENT_BITS-1:0] mat_ff [mvm_pkg::LANES];
   logic signed [mvm_pkg::PROD_BITS-1:0]    prod [mvm_pkg::LANES];
   mvm_pkg::stage_ctl_type                  s1_ctl_ff;
   mvm_pkg::stage_ctl_type                  s1_ctl_in;
   mvm_pkg::stage_ctl_type                  s2_ctl_ff;
   mvm_pkg::stage_ctl_type                  s2_ctl_in;
   logic                                    merge_ready;
   logic                                    s1_take;
   logic                                    s2_take;
   logic                                    accept;
   logic                                    in_range;
   logic                                    is_last;
   logic                                    vec_write;
   logic                                    mat_accept;

   // Group count register.
   assign groups_in_use_in = csr_we ? csr_wdata : groups_in_use_ff;
   assign groups           = mvm_pkg::eff_groups(groups_in_use_ff);

   // Input beat decode.
   assign in_range   = ({1'b0, req_bus.col_group} < groups);
   assign is_last    = ({1'b0, req_bus.col_group} == groups - mvm_pkg::groups_type'(1));
   assign accept     = req_bus.valid && req_bus.ready;
   assign vec_write  = accept && in_range && (req_bus.req_type == mvm_pkg::REQ_VECTOR);
   assign mat_accept = accept && in_range && (req_bus.req_type == mvm_pkg::REQ_MATRIX);
   assign vec_word   = {req_bus.lane3, req_bus.lane2, req_bus.lane1, req_bus.lane0};
   assign mat_in[0]  = req_bus.lane0;
   assign mat_in[1]  = req_bus.lane1;
   assign mat_in[2]  = req_bus.lane2;
   assign mat_in[3]  = req_bus.lane3;

   // Stage handshake: a stage takes a beat when it is empty or its beat moves on.
   assign s2_take     = !s2_ctl_ff.valid || merge_ready;
   assign s1_take     = !s1_ctl_ff.valid || s2_take;
   assign req_bus.ready = s1_take;

   always_comb begin
      s1_ctl_in = s1_ctl_ff;
      s2_ctl_in = s2_ctl_ff;
      if (s1_take) begin
         s1_ctl_in.valid = mat_accept;
         s1_ctl_in.last  = is_last;
      end
      if (s2_take) begin
         s2_ctl_in = s1_ctl_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         groups_in_use_ff <= mvm_pkg::CFG_BITS'(mvm_pkg::GROUPS);
         s1_ctl_ff        <= '0;
         s2_ctl_ff        <= '0;
      end else begin
         groups_in_use_ff <= groups_in_use_in;
         s1_ctl_ff        <= s1_ctl_in;
         s2_ctl_ff        <= s2_ctl_in;
      end
   end

   // Vector store: one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (vec_write) begin
         vector_store[req_bus.col_group] <= vec_word;
      end
      if (mat_accept) begin
         vec_rd_ff <= vector_store[req_bus.col_group];
      end
   end

   // Matrix elements held next to the vector read data.
   always_ff @(posedge clock) begin
      if (mat_accept) begin
         mat_ff <= mat_in;
      end
   end

   // Lane array.
   for (genvar k = 0; k < mvm_pkg::LANES; k++) begin : g_lane
      mvm_lane u_lane (
         .clock    (clock),
         .load     (s2_take && s1_ctl_ff.valid),
         .mat_elem (mat_ff[k]),
         .vec_elem (vec_rd_ff[k*mvm_pkg::ELEMENT_BITS +: mvm_pkg::ELEMENT_BITS]),
         .prod_ff  (prod[k])
      );
   end

   // Adder tree, accumulator and output register.
   mvm_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (s2_ctl_ff),
      .prod     (prod),
      .groups   (groups),
      .in_ready (merge_ready),
      .rsp      (rsp_bus)
   );

endmodule

// ===== design/mvm_checker.sv =====
// Port-level checks for the matrix-vector multiplier and their binding to the top level.
`timescale 1ns / 1ps

module mvm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [mvm_pkg::ROW_BITS-1:0]        rsp_row_index,
   input logic signed [mvm_pkg::ACC_BITS-1:0] rsp_row_sum
);

   // A response beat that is not taken holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_index) && $stable(rsp_row_sum))
      else $error("response beat changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // With the response side ready nothing in the pipeline stalls.
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request side stalled while response side was ready");

   // A first result cannot appear sooner than the pipeline depth after reset.
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3))
      else $error("response beat appeared too soon after reset");

endmodule

bind matrix_vector_multiply_top mvm_checker u_mvm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_row_index (rsp_bus.row_index),
   .rsp_row_sum   (rsp_bus.row_sum)
);

// ===== tb/tb_matrix_vector_multiply_top.sv =====
// Self-checking testbench for the matrix-vector multiplier top level.
`timescale 1ns / 1ps

module tb_matrix_vector_multiply_top;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int DRAIN_CYCLES  = 12;
   localparam int END_WAIT      = 20000;
   localparam int HOLD_CYCLES   = 200;

   typedef logic [mvm_pkg::LANES-1:0][mvm_pkg::ELEMENT_BITS-1:0] lane_group_type;

   typedef struct {
      logic [mvm_pkg::ROW_BITS-1:0] row;
      logic [mvm_pkg::ACC_BITS-1:0] sum;
   } row_result_type;

   // Scoreboard: mirrors the vector store, row accumulator and row counter, and
   // holds the row results that are due from the block in order.
   class row_product_board;
      lane_group_type               vec_word [mvm_pkg::GROUPS];
      logic [mvm_pkg::ACC_BITS-1:0] acc;
      logic [mvm_pkg::ROW_BITS-1:0] row_cnt;
      logic [mvm_pkg::CFG_BITS-1:0] groups_raw;
      row_result_type               rows_due [$];
      int                           mismatches;

      function new();
         acc        = '0;
         row_cnt    = '0;
         groups_raw = mvm_pkg::CFG_BITS'(mvm_pkg::GROUPS);
         mismatches = 0;
         foreach (vec_word[i]) vec_word[i] = '0;
      endfunction

      // Zero acts as one group and values above the store size act as the full size.
      function int group_count();
         if (groups_raw == '0) return 1;
         if (int'(groups_raw) > mvm_pkg::GROUPS) return mvm_pkg::GROUPS;
         return int'(groups_raw);
      endfunction

      function void set_groups(input logic [mvm_pkg::CFG_BITS-1:0] raw);
         groups_raw = raw;
      endfunction

      function int pending();
         return rows_due.size();
      endfunction

      task report_mismatch(input string msg);
         mismatches++;
         $display("MISMATCH: %s", msg);
      endtask

      // Fold one accepted request beat into the mirrored state.
      function void note_beat(input mvm_pkg::req_kind_type kind,
                              input logic [mvm_pkg::GROUP_BITS-1:0] cg,
                              input lane_group_type lanes);
         int             g;
         longint         prod;
         row_result_type res;
         g = group_count();
         // A beat whose column group is beyond the size in use is dropped.
         if (int'(cg) >= g) return;
         if (kind == mvm_pkg::REQ_VECTOR) begin
            vec_word[cg] = lanes;
            return;
         end
         for (int k = 0; k < mvm_pkg::LANES; k++) begin
            prod = longint'($signed(lanes[k])) * longint'($signed(vec_word[cg][k]));
            acc  = acc + prod[mvm_pkg::ACC_BITS-1:0];
         end
         if (int'(cg) != g - 1) return;
         res.row = row_cnt;
         res.sum = acc;
         rows_due.push_back(res);
         acc = '0;
         // The counter wraps after the last row, also when it already sits past it.
         if (int'(row_cnt) + 1 >= g * mvm_pkg::LANES) row_cnt = '0;
         else row_cnt = row_cnt + 1'b1;
      endfunction

      // Compare one accepted response beat with the oldest row still due.
      task check_row(input logic [mvm_pkg::ROW_BITS-1:0] row,
                     input logic [mvm_pkg::ACC_BITS-1:0] sum);
         row_result_type res;
         if (rows_due.size() == 0) begin
            report_mismatch($sformatf("unexpected row %0d sum %0d", row, $signed(sum)));
         end else begin
            res = rows_due.pop_front();
            if (row !== res.row)
               report_mismatch($sformatf("row_index %0d, expected %0d", row, res.row));
            if (sum !== res.sum)
               report_mismatch($sformatf("row %0d row_sum %0d, expected %0d", res.row,
                                         $signed(sum), $signed(res.sum)));
         end
      endtask

      task flush_leftovers();
         if (rows_due.size() != 0)
            report_mismatch($sformatf("%0d row results never arrived", rows_due.size()));
      endtask
   endclass

   logic                         clock;
   logic                         reset;
   logic                         csr_we;
   logic [mvm_pkg::CFG_BITS-1:0] csr_wdata;

   mvm_req_if req_bus ();
   mvm_rsp_if rsp_bus ();

   row_product_board board;
   bit               idle_on;
   bit               hold_request;
   int               cycle_count;

   matrix_vector_multiply_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Clock generation.
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Elements lean toward the extremes of the signed range.
   function automatic logic [mvm_pkg::ELEMENT_BITS-1:0] pick_element();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         3: return 16'h0000;
         default: return mvm_pkg::ELEMENT_BITS'($urandom);
      endcase
   endfunction

   function automatic lane_group_type random_lanes();
      lane_group_type lanes;
      for (int k = 0; k < mvm_pkg::LANES; k++) lanes[k] = pick_element();
      return lanes;
   endfunction

   function automatic lane_group_type make_lanes(input int e0, input int e1, input int e2,
                                                 input int e3);
      lane_group_type lanes;
      lanes[0] = e0[mvm_pkg::ELEMENT_BITS-1:0];
      lanes[1] = e1[mvm_pkg::ELEMENT_BITS-1:0];
      lanes[2] = e2[mvm_pkg::ELEMENT_BITS-1:0];
      lanes[3] = e3[mvm_pkg::ELEMENT_BITS-1:0];
      return lanes;
   endfunction

   // Offer one request beat, after an optional idle burst, and wait for acceptance.
   task automatic send_beat(input mvm_pkg::req_kind_type kind, input int cg,
                            input lane_group_type lanes);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= kind;
      req_bus.col_group <= cg[mvm_pkg::GROUP_BITS-1:0];
      req_bus.lane0     <= lanes[0];
      req_bus.lane1     <= lanes[1];
      req_bus.lane2     <= lanes[2];
      req_bus.lane3     <= lanes[3];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_beat(kind, cg[mvm_pkg::GROUP_BITS-1:0], lanes);
   endtask

   // Let every due row arrive, then let beats without results leave the pipeline.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_groups(input int raw);
      csr_we    <= 1'b1;
      csr_wdata <= raw[mvm_pkg::CFG_BITS-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_groups(raw[mvm_pkg::CFG_BITS-1:0]);
   endtask

   // One setting of the group count: load the vector, then mostly whole rows with noise.
   task automatic run_phase(input int raw_cfg, input int budget, input bit squeeze,
                            input bit pause_mid);
      int g;
      int done;
      int pick;
      int cg;
      bit paused;
      wait_idle();
      write_groups(raw_cfg);
      g = board.group_count();
      for (cg = 0; cg < g; cg++) send_beat(mvm_pkg::REQ_VECTOR, cg, random_lanes());
      if (squeeze) hold_request = 1'b1;
      done   = 0;
      paused = 1'b0;
      while (done < budget) begin
         if (pause_mid && !paused && done >= budget / 2) begin
            // Sender goes quiet until the block has delivered everything.
            paused = 1'b1;
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (board.pending() != 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            for (cg = 0; cg < g; cg++) send_beat(mvm_pkg::REQ_MATRIX, cg, random_lanes());
            done += g;
         end else if (pick < 75) begin
            send_beat(mvm_pkg::REQ_MATRIX, g - 1, random_lanes());
            done++;
         end else if (pick < 85) begin
            send_beat(mvm_pkg::REQ_VECTOR, $urandom_range(0, g - 1), random_lanes());
            done++;
         end else if (pick < 93 || g == mvm_pkg::GROUPS) begin
            send_beat(mvm_pkg::REQ_MATRIX, $urandom_range(0, g - 1), random_lanes());
            done++;
         end else begin
            send_beat(mvm_pkg::req_kind_type'($urandom_range(0, 1)),
                      $urandom_range(g, mvm_pkg::GROUPS - 1), random_lanes());
         end
      end
   endtask

   // Response side: check accepted beats and stall in bursts or one long hold.
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            board.check_row(rsp_bus.row_index, rsp_bus.row_sum);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Run limit.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // Main sequence.
   initial begin
      int waited;
      board        = new();
      idle_on      = 1'b1;
      hold_request = 1'b0;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.req_type  <= mvm_pkg::REQ_VECTOR;
      req_bus.col_group <= '0;
      req_bus.lane0     <= '0;
      req_bus.lane1     <= '0;
      req_bus.lane2     <= '0;
      req_bus.lane3     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme elements at the first and last column group of the reset size.
      send_beat(mvm_pkg::REQ_VECTOR, 0, make_lanes(32767, -32768, 0, -1));
      send_beat(mvm_pkg::REQ_VECTOR, mvm_pkg::GROUPS - 1,
                make_lanes(-32768, -32768, 32767, 32767));
      send_beat(mvm_pkg::REQ_MATRIX, 0, make_lanes(32767, -32768, 1, -1));
      send_beat(mvm_pkg::REQ_MATRIX, mvm_pkg::GROUPS - 1,
                make_lanes(-32768, 32767, 32767, -32768));
      send_beat(mvm_pkg::REQ_MATRIX, mvm_pkg::GROUPS - 1,
                make_lanes(-32768, -32768, -32768, -32768));
      // A repeated group within one row accumulates twice.
      send_beat(mvm_pkg::REQ_MATRIX, 0, make_lanes(-1, -1, -1, -1));
      send_beat(mvm_pkg::REQ_MATRIX, 0, make_lanes(-1, -1, -1, -1));
      send_beat(mvm_pkg::REQ_MATRIX, mvm_pkg::GROUPS - 1,
                make_lanes(32767, 32767, 32767, 32767));

      // Zero acts as one group; the counter wraps after the last row.
      wait_idle();
      write_groups(0);
      repeat (5) send_beat(mvm_pkg::REQ_MATRIX, 0,
                           make_lanes(-32768, -32768, -32768, -32768));
      // Beats of either kind beyond the size in use are dropped.
      send_beat(mvm_pkg::REQ_VECTOR, 1, make_lanes(1, 2, 3, 4));
      send_beat(mvm_pkg::REQ_MATRIX, 1, make_lanes(5, 6, 7, 8));
      send_beat(mvm_pkg::REQ_VECTOR, 64, make_lanes(-1, -1, -1, -1));
      send_beat(mvm_pkg::REQ_MATRIX, mvm_pkg::GROUPS - 1, make_lanes(-1, -1, -1, -1));
      send_beat(mvm_pkg::REQ_MATRIX, 0, make_lanes(0, 0, 0, 0));

      // Values above the store size act as the full size.
      wait_idle();
      write_groups(255);
      send_beat(mvm_pkg::REQ_MATRIX, mvm_pkg::GROUPS - 1,
                make_lanes(32767, -32768, 32767, -32768));
      wait_idle();
      write_groups(1);
      send_beat(mvm_pkg::REQ_VECTOR, 0, make_lanes(-32768, 32767, -1, 1));
      send_beat(mvm_pkg::REQ_MATRIX, 0, make_lanes(-32768, -32768, 32767, 32767));
      send_beat(mvm_pkg::REQ_MATRIX, 0, make_lanes(32767, 0, -32768, 0));

      // Random phases over several sizes, extremes among them.
      run_phase(255, 120, 1'b0, 1'b0);
      run_phase(1, 80, 1'b1, 1'b0);
      run_phase(2, 50, 1'b0, 1'b0);
      run_phase(3, 50, 1'b0, 1'b1);
      run_phase(0, 40, 1'b0, 1'b0);
      run_phase($urandom_range(4, 20), 60, 1'b0, 1'b0);
      run_phase($urandom_range(21, 127), 100, 1'b0, 1'b0);
      run_phase(128, 60, 1'b0, 1'b0);
      run_phase($urandom_range(129, 254), 30, 1'b0, 1'b0);
      // Last stretch runs at full rate on both sides.
      wait_idle();
      idle_on = 1'b0;
      run_phase(5, 60, 1'b0, 1'b0);

      // Drain and decide.
      req_bus.valid <= 1'b0;
      waited = 0;
      while (board.pending() != 0 && waited < END_WAIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      board.flush_leftovers();
      if (board.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
